@@ src/triangle_scanline_span_generator_assert.svh @@
// Assertion macros for the triangle span generator.
`ifndef TRIANGLE_SCANLINE_SPAN_GENERATOR_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TSSG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tssg assertion failed");
// next-cycle implication
`define TSSG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tssg assertion failed");
`else
`define TSSG_ASSERT_IMP(label, clk, rst, ante, cons)
`define TSSG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/tssg_pkg.sv @@
// Shared types for the triangle span generator.
package tssg_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lerp_status_t;

endpackage

@@ src/tssg_lerp.sv @@
// Bit-serial edge interpolator: xa + trunc(dx * k / h), one bit per cycle.
module tssg_lerp import tssg_pkg::*; #(
  parameter int CB = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CB-1:0] xa,
  input  logic signed [CB:0]   dx,
  input  logic        [CB-1:0] k,
  input  logic        [CB-1:0] h,
  output logic signed [CB:0]   result,
  output lerp_status_t         status
);

  localparam int CNT_W = $clog2(CB);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CB - 1);

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIX
  } lstate_t;

  lstate_t               state;
  logic [CNT_W-1:0]      cnt;
  logic [CB-1:0]         hi;
  logic [CB-1:0]         lo;
  logic [CB-1:0]         mag;
  logic                  neg;
  logic signed [CB-1:0]  xa_q;
  logic [CB-1:0]         h_q;
  logic                  done;

  logic [CB:0] dx_abs;
  logic [CB:0] mul_sum;
  logic [CB:0] div_t;
  logic [CB:0] div_diff;
  logic        div_ge;
  logic [CB:0] q_signed;

  always_comb begin
    dx_abs   = dx[CB] ? (~dx + 1'b1) : dx;
    mul_sum  = {1'b0, hi} + (lo[0] ? {1'b0, mag} : '0);
    div_t    = {hi, lo[CB-1]};
    div_diff = div_t - {1'b0, h_q};
    div_ge   = (div_t >= {1'b0, h_q});
    q_signed = neg ? (~{1'b0, lo} + 1'b1) : {1'b0, lo};
  end

  assign status.busy = (state != L_IDLE);
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            hi    <= '0;
            lo    <= k;
            mag   <= dx_abs[CB-1:0];
            neg   <= dx[CB];
            xa_q  <= xa;
            h_q   <= h;
            cnt   <= '0;
            state <= L_MUL;
          end
        end
        // LSB-first shift-add: product ends up in {hi, lo}
        L_MUL: begin
          hi <= mul_sum[CB:1];
          lo <= {mul_sum[0], lo[CB-1:1]};
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= L_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        // restoring division; quotient bits shift into lo
        L_DIV: begin
          hi <= div_ge ? div_diff[CB-1:0] : div_t[CB-1:0];
          lo <= {lo[CB-2:0], div_ge};
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= L_FIX;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        L_FIX: begin
          result <= $signed({xa_q[CB-1], xa_q}) + $signed(q_signed);
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

@@ src/triangle_scanline_span_generator.sv @@
// Top level of the triangle scanline span generator.
// A beat with tuser = load (0) carries three vertices and a fill color; the
// vertices are sorted by y and held, and a triangle whose three y are equal
// is dropped. Each beat with tuser = step (1) yields one span for row
// y0+i: left and right x, the color, and tlast on the final row (the bottom
// vertex row is not drawn). A step with no triangle held gives no beat.
// A step runs two bit-serial interpolators side by side (long edge and
// short edge), each doing a shift-add multiply, a restoring divide and a
// fixup step; the next beat is taken once the lanes have finished and the
// output stage has loaded the span, which it does only when the output
// register is free. The output register holds a finished span until
// taken, so a load may enter while a span waits downstream; a new step
// waits only for the output stage.
`include "triangle_scanline_span_generator_assert.svh"

module triangle_scanline_span_generator import tssg_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // x0, y0, x1, y1, x2, y2, color (low bit up), zero pad to bytes
  input  logic [((6*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
  // op
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // span_y, span_x_left, span_x_right, span_color (low bit up), zero pad
  output logic [((3*COORD_BITS+32+7)/8)*8-1:0] m_tdata,
  // span_last
  output logic                      m_tlast
);

  localparam int C     = COORD_BITS;
  localparam int OUT_W = ((3*C+32+7)/8)*8;

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_OUT
  } tstate_t;

  tstate_t             state;
  logic signed [C-1:0] sx [3];
  logic signed [C-1:0] sy [3];
  logic [C:0]          row;
  logic [31:0]         fill_color;
  logic                active;

  // input unpack
  logic signed [C-1:0] in_x [3];
  logic signed [C-1:0] in_y [3];
  logic [31:0]         in_color;

  assign in_x[0]  = s_tdata[C-1:0];
  assign in_y[0]  = s_tdata[2*C-1:C];
  assign in_x[1]  = s_tdata[3*C-1:2*C];
  assign in_y[1]  = s_tdata[4*C-1:3*C];
  assign in_x[2]  = s_tdata[5*C-1:4*C];
  assign in_y[2]  = s_tdata[6*C-1:5*C];
  assign in_color = s_tdata[6*C+31:6*C];

  logic in_acc;
  logic is_load;
  logic lane_start;

  assign s_tready   = (state == T_IDLE);
  assign in_acc     = s_tvalid && s_tready;
  assign is_load    = (op_t'(s_tuser) == OP_LOAD);
  assign lane_start = in_acc && !is_load && active;

  // three compare-and-swap steps on strictly greater y
  logic signed [C-1:0] srt_x [3];
  logic signed [C-1:0] srt_y [3];
  logic                flat;

  always_comb begin
    logic signed [C-1:0] tx;
    logic signed [C-1:0] ty;
    tx = '0;
    ty = '0;
    for (int n = 0; n < 3; n++) begin
      srt_x[n] = in_x[n];
      srt_y[n] = in_y[n];
    end
    if (srt_y[0] > srt_y[1]) begin
      tx = srt_x[0]; srt_x[0] = srt_x[1]; srt_x[1] = tx;
      ty = srt_y[0]; srt_y[0] = srt_y[1]; srt_y[1] = ty;
    end
    if (srt_y[0] > srt_y[2]) begin
      tx = srt_x[0]; srt_x[0] = srt_x[2]; srt_x[2] = tx;
      ty = srt_y[0]; srt_y[0] = srt_y[2]; srt_y[2] = ty;
    end
    if (srt_y[1] > srt_y[2]) begin
      tx = srt_x[1]; srt_x[1] = srt_x[2]; srt_x[2] = tx;
      ty = srt_y[1]; srt_y[1] = srt_y[2]; srt_y[2] = ty;
    end
    flat = (in_y[0] == in_y[1]) && (in_y[0] == in_y[2]);
  end

  // edge setup from held vertices; heights are never negative after sorting
  logic [C:0]          total;
  logic [C:0]          upper;
  logic [C:0]          lower;
  logic                second;
  logic                span_last;
  logic [C:0]          k_low;
  logic signed [C:0]   dx02;
  logic signed [C:0]   dx01;
  logic signed [C:0]   dx12;
  logic signed [C-1:0] b_xa;
  logic signed [C:0]   b_dx;
  logic [C-1:0]        b_k;
  logic [C-1:0]        b_h;

  always_comb begin
    total     = {sy[2][C-1], sy[2]} - {sy[0][C-1], sy[0]};
    upper     = {sy[1][C-1], sy[1]} - {sy[0][C-1], sy[0]};
    lower     = {sy[2][C-1], sy[2]} - {sy[1][C-1], sy[1]};
    second    = (row > upper) || (upper == '0);
    span_last = (({1'b0, row} + 1'b1) >= {1'b0, total});
    k_low     = row - upper;
    dx02      = {sx[2][C-1], sx[2]} - {sx[0][C-1], sx[0]};
    dx01      = {sx[1][C-1], sx[1]} - {sx[0][C-1], sx[0]};
    dx12      = {sx[2][C-1], sx[2]} - {sx[1][C-1], sx[1]};
    if (second) begin
      b_xa = sx[1];
      b_dx = dx12;
      b_k  = k_low[C-1:0];
      b_h  = lower[C-1:0];
    end else begin
      b_xa = sx[0];
      b_dx = dx01;
      b_k  = row[C-1:0];
      b_h  = upper[C-1:0];
    end
  end

  logic signed [C:0] ax;
  logic signed [C:0] bx;
  lerp_status_t      la_st;
  lerp_status_t      lb_st;

  // long edge, v0 to v2
  tssg_lerp #(.CB(C)) u_lerp_a (
    .clk    (clk),
    .rst    (rst),
    .start  (lane_start),
    .xa     (sx[0]),
    .dx     (dx02),
    .k      (row[C-1:0]),
    .h      (total[C-1:0]),
    .result (ax),
    .status (la_st)
  );

  // short edge of the current half
  tssg_lerp #(.CB(C)) u_lerp_b (
    .clk    (clk),
    .rst    (rst),
    .start  (lane_start),
    .xa     (b_xa),
    .dx     (b_dx),
    .k      (b_k),
    .h      (b_h),
    .result (bx),
    .status (lb_st)
  );

  logic          out_load;
  logic [C-1:0]  x_left;
  logic [C-1:0]  x_right;
  logic [C-1:0]  span_y;

  assign out_load = (state == T_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    if (ax > bx) begin
      x_left  = bx[C-1:0];
      x_right = ax[C-1:0];
    end else begin
      x_left  = ax[C-1:0];
      x_right = bx[C-1:0];
    end
    span_y = sy[0] + row[C-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      active     <= 1'b0;
      row        <= '0;
      fill_color <= '0;
      m_tvalid   <= 1'b0;
      for (int n = 0; n < 3; n++) begin
        sx[n] <= '0;
        sy[n] <= '0;
      end
    end else begin
      // a taken beat clears valid unless a new span is loaded this cycle
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_acc && is_load) begin
            for (int n = 0; n < 3; n++) begin
              sx[n] <= srt_x[n];
              sy[n] <= srt_y[n];
            end
            fill_color <= in_color;
            row        <= '0;
            active     <= !flat;
          end else if (lane_start) begin
            state <= T_RUN;
          end
        end
        T_RUN: begin
          if (la_st.done) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_load) begin
            m_tdata  <= OUT_W'({fill_color, x_right, x_left, span_y});
            m_tlast  <= span_last;
            m_tvalid <= 1'b1;
            if (span_last) begin
              active <= 1'b0;
              row    <= '0;
            end else begin
              row <= row + 1'b1;
            end
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // input is taken only while both lanes are quiet
  `TSSG_ASSERT_IMP(a_ready_lanes_idle, clk, rst, s_tready, !la_st.busy && !lb_st.busy)
  // both lanes run in lockstep
  `TSSG_ASSERT_IMP(a_lanes_lockstep, clk, rst, la_st.done || lb_st.done, la_st.done && lb_st.done)
  // an accepted step on a held triangle starts the lanes
  `TSSG_ASSERT_NXT(a_step_starts, clk, rst, lane_start, la_st.busy && lb_st.busy)
  // the last span retires the triangle
  `TSSG_ASSERT_NXT(a_last_retires, clk, rst, out_load && span_last, !active && m_tlast)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the triangle scanline span generator.
module tb_top import tssg_pkg::*; ();

  localparam int CW      = 12;
  localparam int IN_W    = ((6*CW+32+7)/8)*8;
  localparam int OUT_W   = ((3*CW+32+7)/8)*8;
  localparam int DRAIN   = 2*CW + 40;     // quiet cycles after the last span
  localparam int STALL_LIMIT = 4000;      // cycles with no beat on either side
  localparam int RAND_PER_PHASE = 545;

  typedef struct packed {
    op_t             op;
    logic [CW-1:0]   x0, y0, x1, y1, x2, y2;
    logic [31:0]     color;
  } tri_beat_t;

  typedef struct packed {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] xl;
    logic signed [CW-1:0] xr;
    logic [31:0]          color;
    logic                 last;
  } span_t;

  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_NO_SPAN,
    ROW_TYPED_SPAN
  } row_kind_t;

  typedef struct packed {
    tri_beat_t beat;
    row_kind_t kind;
    span_t     span;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = OP_LOAD;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  triangle_scanline_span_generator #(.COORD_BITS(CW)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted triangle state
  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic [CW:0]          row_cnt;
  logic [31:0]          tri_color;
  bit                   tri_live;

  span_t expected_spans [$];
  span_t got_span, want_span;

  int errors = 0;
  int spans_checked = 0;
  int counted_items = 0;
  int loads_sent = 0;
  int flat_loads = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int quiet_cycles = 0;

  // xa + dx*k/h, quotient truncated toward zero
  function automatic longint edge_x(longint xa, longint dx, longint k, longint h);
    if (h == 0) return xa;
    return xa + (dx * k) / h;
  endfunction

  function automatic void swap_vertex(int a, int b);
    logic signed [CW-1:0] t;
    t = vx[a]; vx[a] = vx[b]; vx[b] = t;
    t = vy[a]; vy[a] = vy[b]; vy[b] = t;
  endfunction

  // Advances the predicted state by one beat; returns 1 when a span results.
  function automatic bit predict_span(tri_beat_t b, output span_t sp);
    longint total, upper, i, ax, bx, t;
    bit lower_half;
    sp = '0;
    if (b.op == OP_LOAD) begin
      vx[0] = b.x0; vy[0] = b.y0;
      vx[1] = b.x1; vy[1] = b.y1;
      vx[2] = b.x2; vy[2] = b.y2;
      tri_color = b.color;
      row_cnt = '0;
      if (vy[0] == vy[1] && vy[0] == vy[2]) begin
        tri_live = 1'b0;
        return 1'b0;
      end
      if (vy[0] > vy[1]) swap_vertex(0, 1);
      if (vy[0] > vy[2]) swap_vertex(0, 2);
      if (vy[1] > vy[2]) swap_vertex(1, 2);
      tri_live = 1'b1;
      return 1'b0;
    end
    if (!tri_live) return 1'b0;

    total = longint'(vy[2]) - longint'(vy[0]);
    upper = longint'(vy[1]) - longint'(vy[0]);
    i     = longint'(row_cnt);
    // tie row stays in the upper half unless the top edge is flat
    lower_half = (i > upper) || (upper == 0);
    ax = edge_x(longint'(vx[0]), longint'(vx[2]) - longint'(vx[0]), i, total);
    if (lower_half)
      bx = edge_x(longint'(vx[1]), longint'(vx[2]) - longint'(vx[1]), i - upper,
                  longint'(vy[2]) - longint'(vy[1]));
    else
      bx = edge_x(longint'(vx[0]), longint'(vx[1]) - longint'(vx[0]), i, upper);
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
    end
    sp.y     = CW'(longint'(vy[0]) + i);
    sp.xl    = CW'(ax);
    sp.xr    = CW'(bx);
    sp.color = tri_color;
    sp.last  = (i + 1 >= total);
    if (sp.last) begin
      tri_live = 1'b0;
      row_cnt  = '0;
    end else begin
      row_cnt = row_cnt + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic tri_beat_t mk_beat(op_t op, int x0, int y0, int x1, int y1,
                                        int x2, int y2, logic [31:0] c);
    tri_beat_t b;
    b.op = op;
    b.x0 = CW'(x0); b.y0 = CW'(y0);
    b.x1 = CW'(x1); b.y1 = CW'(y1);
    b.x2 = CW'(x2); b.y2 = CW'(y2);
    b.color = c;
    return b;
  endfunction

  function automatic span_t mk_span(int y, int xl, int xr, logic [31:0] c, bit last);
    span_t s;
    s.y = CW'(y); s.xl = CW'(xl); s.xr = CW'(xr);
    s.color = c; s.last = last;
    return s;
  endfunction

  function automatic dir_row_t mk_row(tri_beat_t b, row_kind_t k, span_t s);
    dir_row_t r;
    r.beat = b; r.kind = k; r.span = s;
    return r;
  endfunction

  function automatic int rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) return -2048;
    if (r < 20) return 2047;
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // Drives one beat from the falling edge, holds it until taken, then
  // updates the prediction at the accepting edge.
  task automatic send_beat(tri_beat_t b, row_kind_t kind, span_t typed);
    span_t pred;
    bit    has_span;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= b.op;
    s_tdata  <= {b.color, b.y2, b.x2, b.y1, b.x1, b.y0, b.x0};
    do @(posedge clk); while (!s_tready);
    if (b.op == OP_LOAD || tri_live) counted_items++;
    if (b.op == OP_LOAD) begin
      loads_sent++;
      if (b.y0 == b.y1 && b.y0 == b.y2) flat_loads++;
    end
    has_span = predict_span(b, pred);
    case (kind)
      ROW_PREDICTED:  if (has_span) expected_spans.push_back(pred);
      ROW_TYPED_SPAN: expected_spans.push_back(typed);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_step();
    tri_beat_t  b;
    logic [127:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom};
    b = rnd[$bits(tri_beat_t)-1:0];
    b.op = OP_STEP;
    send_beat(b, ROW_PREDICTED, '0);
  endtask

  // Mostly whole triangles walked to their last row, with abandoned
  // triangles, flat ones, tall ones and stray steps mixed in.
  task automatic random_items(int budget);
    int stop, flavor, h, mid, ybase, k, j, n, limit, t;
    int xs [3];
    int ys [3];
    stop = counted_items + budget;
    while (counted_items < stop) begin
      flavor = $urandom_range(99);
      if (flavor < 5) begin
        send_step();
      end else begin
        h = (flavor < 12) ? 0 : $urandom_range(1, 40);
        ybase = $urandom_range(0, 4095 - h) - 2048;
        case ($urandom_range(4))
          0:       mid = 0;
          1:       mid = h;
          default: mid = $urandom_range(0, h);
        endcase
        ys[0] = ybase; ys[1] = ybase + mid; ys[2] = ybase + h;
        if (flavor >= 12 && flavor < 17) begin
          for (k = 0; k < 3; k++) ys[k] = int'($urandom_range(0, 4095)) - 2048;
        end
        for (k = 0; k < 3; k++) xs[k] = rand_coord();
        for (k = 2; k > 0; k--) begin
          j = $urandom_range(k, 0);
          t = xs[k]; xs[k] = xs[j]; xs[j] = t;
          t = ys[k]; ys[k] = ys[j]; ys[j] = t;
        end
        send_beat(mk_beat(OP_LOAD, xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom),
                  ROW_PREDICTED, '0);
        if (flavor >= 12 && flavor < 17) limit = $urandom_range(1, 6);
        else if ($urandom_range(9) == 0) limit = $urandom_range(1, 3);
        else limit = 1 << 20;
        n = 0;
        while (tri_live && n < limit) begin
          send_step();
          n++;
        end
        if ($urandom_range(9) == 0) send_step();
      end
    end
  endtask

  // Receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Span checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_span.y     = m_tdata[CW-1:0];
      got_span.xl    = m_tdata[2*CW-1:CW];
      got_span.xr    = m_tdata[3*CW-1:2*CW];
      got_span.color = m_tdata[3*CW+31:3*CW];
      got_span.last  = m_tlast;
      if (expected_spans.size() == 0) begin
        $error("span beat with none expected: y %0d left %0d right %0d",
               got_span.y, got_span.xl, got_span.xr);
        errors++;
      end else begin
        want_span = expected_spans.pop_front();
        spans_checked++;
        if (got_span.y !== want_span.y) begin
          $error("span_y: expected %0d, got %0d", want_span.y, got_span.y);
          errors++;
        end
        if (got_span.xl !== want_span.xl) begin
          $error("span_x_left: expected %0d, got %0d", want_span.xl, got_span.xl);
          errors++;
        end
        if (got_span.xr !== want_span.xr) begin
          $error("span_x_right: expected %0d, got %0d", want_span.xr, got_span.xr);
          errors++;
        end
        if (got_span.color !== want_span.color) begin
          $error("span_color: expected %h, got %h", want_span.color, got_span.color);
          errors++;
        end
        if (got_span.last !== want_span.last) begin
          $error("span_last: expected %0d, got %0d", want_span.last, got_span.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends a run that stops moving beats
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  dir_row_t dir_rows [$];

  initial begin
    int r, ph;
    tri_live  = 1'b0;
    row_cnt   = '0;
    tri_color = '0;
    for (r = 0; r < 3; r++) begin
      vx[r] = '0;
      vy[r] = '0;
    end

    // step with nothing loaded
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_NO_SPAN, '0));
    // flat triangle is dropped, so the next step gives nothing
    dir_rows.push_back(mk_row(mk_beat(OP_LOAD, 3, 7, -5, 7, 100, 7, 32'h1234_5678),
                              ROW_NO_SPAN, '0));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_NO_SPAN, '0));
    // one-row triangle: a single span that is also the last
    dir_rows.push_back(mk_row(mk_beat(OP_LOAD, 0, 0, 0, 1, 0, 1, 32'h0), ROW_NO_SPAN, '0));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_TYPED_SPAN,
                              mk_span(0, 0, 0, 32'h0, 1'b1)));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_NO_SPAN, '0));
    // full-range triangle, flat top: first row spans the whole width
    dir_rows.push_back(mk_row(mk_beat(OP_LOAD, -2048, -2048, 2047, -2048, 0, 2047,
                                      32'hFFFF_FFFF), ROW_NO_SPAN, '0));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_TYPED_SPAN,
                              mk_span(-2048, -2048, 2047, 32'hFFFF_FFFF, 1'b0)));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_PREDICTED, '0));
    // replaces the active triangle; unsorted, tie row in the upper half
    dir_rows.push_back(mk_row(mk_beat(OP_LOAD, 4, 2, -3, 0, 6, 1, 32'hA5A5_A5A5),
                              ROW_PREDICTED, '0));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_PREDICTED, '0));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_PREDICTED, '0));
    // flat top edge: every row uses the lower half
    dir_rows.push_back(mk_row(mk_beat(OP_LOAD, 0, 5, 8, 5, 4, 9, 32'h5A5A_5A5A),
                              ROW_PREDICTED, '0));
    for (r = 0; r < 4; r++)
      dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_PREDICTED, '0));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_NO_SPAN, '0));
    // reversed extremes, abandoned after two rows
    dir_rows.push_back(mk_row(mk_beat(OP_LOAD, 2047, 2047, -2048, -2048, -1, 0,
                                      32'h8000_0001), ROW_PREDICTED, '0));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_PREDICTED, '0));
    dir_rows.push_back(mk_row(mk_beat(OP_STEP, 0, 0, 0, 0, 0, 0, 0), ROW_PREDICTED, '0));

    src_idle_pct = 23;
    dst_idle_pct = 77;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k])
      send_beat(dir_rows[k].beat, dir_rows[k].kind, dir_rows[k].span);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 23; dst_idle_pct = 77; end
        1: begin src_idle_pct = 77; dst_idle_pct = 23; end
        default: begin src_idle_pct = 0; dst_idle_pct = 0; end
      endcase
      random_items(RAND_PER_PHASE);
    end
    s_tvalid <= 1'b0;

    while (expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d counted input beats: %0d triangle loads (%0d flat), %0d spans checked,",
             counted_items, loads_sent, flat_loads, spans_checked);
    $display("under sender-heavy, receiver-heavy and unthrottled handshake mixes.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
